/* rtl/core/assert_macros.svh */
// Assertion helper macros for the address walker.
// No dependencies; pulled in by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(lbl, clk, rstn, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (c)) \
		else $error("implication check failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rstn, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (c)) \
		else $error("next-cycle check failed");

`endif

/* rtl/core/shaw_pkg.sv */
// Shared types, constants and helpers of the strided hyperslab address walker.
// No dependencies.
package shaw_pkg;

	localparam int NUM_DIMS     = 4;
	localparam int DIM_BITS     = 2;
	localparam int RANK_BITS    = 3;
	localparam int INDEX_BITS   = 16;
	localparam int LANE_BITS    = 16;
	localparam int OFFSET_BITS  = 32;
	localparam int CFG_BITS     = 64;
	localparam int CFG_IDX_BITS = 3;
	localparam int STATUS_BITS  = 3;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_RANK        = 3'd0,
		REG_START       = 3'd1,
		REG_COUNT       = 3'd2,
		REG_STRIDE      = 3'd3,
		REG_MAP         = 3'd4,
		REG_ELEM_SIZE   = 3'd5,
		REG_DEFAULT_MAP = 3'd6
	} cfg_reg_t;

	typedef enum logic [STATUS_BITS-1:0] {
		STAT_OK         = 3'd0,
		STAT_BAD_STRIDE = 3'd1,
		STAT_ZERO_COUNT = 3'd2,
		STAT_OVERFLOW   = 3'd3,
		STAT_FINISHED   = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LATCH,
		OP_MUL,
		OP_ACC,
		OP_STEP,
		OP_ERROR,
		OP_FINISHED
	} dp_op_t;

	typedef enum logic [2:0] {
		CS_IDLE,
		CS_CHECK,
		CS_MUL,
		CS_ACC,
		CS_FIRST
	} ctrl_state_t;

	typedef struct packed {
		logic                    we;
		logic [CFG_IDX_BITS-1:0] index;
		logic [CFG_BITS-1:0]     data;
	} cfg_wr_t;

	typedef struct packed {
		status_t chk_err;
		logic    walk_done;
		logic    dim_zero;
	} dp_status_t;

	typedef struct packed {
		logic [NUM_DIMS-1:0][INDEX_BITS-1:0] index;
		logic [OFFSET_BITS-1:0]              offset;
		logic [LANE_BITS-1:0]                run_length;
		logic                                last;
		status_t                             status;
	} out_beat_t;

	function automatic logic [LANE_BITS-1:0] lane(input logic [CFG_BITS-1:0] w,
			input logic [DIM_BITS-1:0] d);
		return w[d*LANE_BITS +: LANE_BITS];
	endfunction

endpackage

/* rtl/core/shaw_if.sv */
// Handshake channels of the address walker: request in, transfer descriptor out.
// Depends on shaw_pkg.
interface shaw_req_if;
	logic valid;
	logic ready;
	logic restart;

	modport source(output valid, output restart, input ready);
	modport sink(input valid, input restart, output ready);
endinterface

interface shaw_rsp_if import shaw_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [INDEX_BITS-1:0]  index_0;
	logic [INDEX_BITS-1:0]  index_1;
	logic [INDEX_BITS-1:0]  index_2;
	logic [INDEX_BITS-1:0]  index_3;
	logic [OFFSET_BITS-1:0] offset;
	logic [LANE_BITS-1:0]   run_length;
	logic                   last;
	logic [STATUS_BITS-1:0] status;

	modport source(output valid, output index_0, output index_1, output index_2,
		output index_3, output offset, output run_length, output last, output status,
		input ready);
	modport sink(input valid, input index_0, input index_1, input index_2,
		input index_3, input offset, input run_length, input last, input status,
		output ready);
endinterface

/* rtl/core/shaw_dp.sv */
// Datapath of the address walker: config registers, walk state, shared map
// multiplier, odometer step and output beat register. Depends on shaw_pkg.
module shaw_dp import shaw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_wr_t    cfg_wr,
	input  dp_op_t     op,
	output dp_status_t stat,
	output out_beat_t  beat
);

	logic [RANK_BITS-1:0]   rank_q;
	logic [CFG_BITS-1:0]    start_words_q;
	logic [CFG_BITS-1:0]    count_words_q;
	logic [CFG_BITS-1:0]    stride_words_q;
	logic [CFG_BITS-1:0]    map_words_q;
	logic [LANE_BITS-1:0]   elem_size_q;
	logic                   default_map_q;

	logic [RANK_BITS-1:0]   rank_h_q;
	logic [DIM_BITS-1:0]    last_dim_q;
	logic                   def_h_q;
	logic                   contig_q;
	logic                   walk_done_q;
	logic [DIM_BITS-1:0]    dim_q;
	logic [LANE_BITS-1:0]   start_q  [NUM_DIMS];
	logic [LANE_BITS-1:0]   count_q  [NUM_DIMS];
	logic [LANE_BITS-1:0]   stride_q [NUM_DIMS];
	logic [LANE_BITS-1:0]   cnt_q    [NUM_DIMS];
	logic [INDEX_BITS-1:0]  idx_q    [NUM_DIMS];
	logic [OFFSET_BITS-1:0] map_q    [NUM_DIMS];
	logic [OFFSET_BITS-1:0] inc_q    [NUM_DIMS];
	logic [OFFSET_BITS-1:0] offset_q;
	logic [OFFSET_BITS-1:0] cum_q;
	logic [OFFSET_BITS-1:0] prod_q;
	out_beat_t              beat_q;

	logic [RANK_BITS-1:0]   eff_rank;
	logic [DIM_BITS-1:0]    eff_last;
	logic [NUM_DIMS-1:0]    used, bad_s, zero_c, ovf_c, adv;
	logic [LANE_BITS-1:0]   cm1      [NUM_DIMS];
	logic [2*LANE_BITS-1:0] span     [NUM_DIMS];
	logic [2*LANE_BITS:0]   last_ix  [NUM_DIMS];
	logic [LANE_BITS:0]     cnt_inc  [NUM_DIMS];
	logic                   found;
	logic [DIM_BITS-1:0]    sel;
	logic [LANE_BITS+OFFSET_BITS-1:0] mul_full;
	status_t                chk_err;

	// rank 0 reads as 1, above the lane count saturates
	always_comb begin
		if (rank_q == '0) begin
			eff_rank = RANK_BITS'(1);
		end else if (rank_q > RANK_BITS'(NUM_DIMS)) begin
			eff_rank = RANK_BITS'(NUM_DIMS);
		end else begin
			eff_rank = rank_q;
		end
		eff_last = DIM_BITS'(eff_rank - RANK_BITS'(1));
	end

	always_comb begin
		for (int d = 0; d < NUM_DIMS; d++) begin
			used[d]    = RANK_BITS'(d) < rank_h_q;
			bad_s[d]   = used[d] && (stride_q[d] == '0 || stride_q[d][LANE_BITS-1]);
			zero_c[d]  = used[d] && (count_q[d] == '0);
			cm1[d]     = count_q[d] - LANE_BITS'(1);
			span[d]    = cm1[d] * stride_q[d];
			last_ix[d] = (2*LANE_BITS+1)'(start_q[d]) + (2*LANE_BITS+1)'(span[d]);
			ovf_c[d]   = used[d] && (|last_ix[d][2*LANE_BITS:LANE_BITS]);
			cnt_inc[d] = {1'b0, cnt_q[d]} + (LANE_BITS+1)'(1);
			adv[d]     = used[d] && !(contig_q && DIM_BITS'(d) == last_dim_q) &&
				(cnt_inc[d] < {1'b0, count_q[d]});
		end
	end

	always_comb begin
		priority if (|bad_s) begin
			chk_err = STAT_BAD_STRIDE;
		end else if (|zero_c) begin
			chk_err = STAT_ZERO_COUNT;
		end else if (|ovf_c) begin
			chk_err = STAT_OVERFLOW;
		end else begin
			chk_err = STAT_OK;
		end
	end

	// fastest dimension that can still advance takes the step
	always_comb begin
		found = 1'b0;
		sel   = '0;
		for (int d = 0; d < NUM_DIMS; d++) begin
			if (adv[d]) begin
				found = 1'b1;
				sel   = DIM_BITS'(d);
			end
		end
	end

	assign mul_full = count_q[dim_q] * map_q[dim_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q         <= RANK_BITS'(1);
			start_words_q  <= '0;
			count_words_q  <= '0;
			stride_words_q <= {NUM_DIMS{LANE_BITS'(1)}};
			map_words_q    <= '0;
			elem_size_q    <= LANE_BITS'(1);
			default_map_q  <= 1'b1;
		end else if (cfg_wr.we) begin
			unique case (cfg_reg_t'(cfg_wr.index))
				REG_RANK:        rank_q         <= cfg_wr.data[RANK_BITS-1:0];
				REG_START:       start_words_q  <= cfg_wr.data;
				REG_COUNT:       count_words_q  <= cfg_wr.data;
				REG_STRIDE:      stride_words_q <= cfg_wr.data;
				REG_MAP:         map_words_q    <= cfg_wr.data;
				REG_ELEM_SIZE:   elem_size_q    <= cfg_wr.data[LANE_BITS-1:0];
				REG_DEFAULT_MAP: default_map_q  <= cfg_wr.data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_done_q <= 1'b1;
		end else begin
			unique case (op)
				OP_STEP:     walk_done_q <= !found;
				OP_ERROR:    walk_done_q <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (op)
			OP_LATCH: begin
				rank_h_q   <= eff_rank;
				last_dim_q <= eff_last;
				def_h_q    <= default_map_q;
				dim_q      <= eff_last;
				offset_q   <= '0;
				cum_q      <= '0;
				contig_q   <= (lane(stride_words_q, eff_last) == LANE_BITS'(1)) &&
					(default_map_q || lane(map_words_q, eff_last) == elem_size_q);
				for (int d = 0; d < NUM_DIMS; d++) begin
					if (RANK_BITS'(d) < eff_rank) begin
						start_q[d]  <= lane(start_words_q, DIM_BITS'(d));
						count_q[d]  <= lane(count_words_q, DIM_BITS'(d));
						stride_q[d] <= lane(stride_words_q, DIM_BITS'(d));
						idx_q[d]    <= INDEX_BITS'(lane(start_words_q, DIM_BITS'(d)));
						if (default_map_q && DIM_BITS'(d) == eff_last) begin
							map_q[d] <= OFFSET_BITS'(elem_size_q);
						end else begin
							map_q[d] <= OFFSET_BITS'(lane(map_words_q, DIM_BITS'(d)));
						end
					end else begin
						start_q[d]  <= '0;
						count_q[d]  <= '0;
						stride_q[d] <= '0;
						idx_q[d]    <= '0;
						map_q[d]    <= '0;
					end
					cnt_q[d] <= '0;
				end
			end
			OP_MUL: begin
				prod_q <= mul_full[OFFSET_BITS-1:0];
			end
			OP_ACC: begin
				// prod_q = count * map of this dimension
				if (def_h_q && dim_q != '0) begin
					map_q[dim_q - DIM_BITS'(1)] <= prod_q;
				end
				inc_q[dim_q] <= map_q[dim_q] + cum_q;
				if (!(contig_q && dim_q == last_dim_q)) begin
					cum_q <= cum_q + map_q[dim_q] - prod_q;
				end
				dim_q <= dim_q - DIM_BITS'(1);
			end
			OP_STEP: begin
				for (int d = 0; d < NUM_DIMS; d++) begin
					beat_q.index[d] <= idx_q[d];
					if (found && DIM_BITS'(d) == sel) begin
						cnt_q[d] <= cnt_inc[d][LANE_BITS-1:0];
						idx_q[d] <= idx_q[d] + INDEX_BITS'(stride_q[d]);
					end else if (used[d] && (!found || DIM_BITS'(d) > sel)) begin
						cnt_q[d] <= '0;
						idx_q[d] <= INDEX_BITS'(start_q[d]);
					end
				end
				beat_q.offset     <= offset_q;
				beat_q.run_length <= contig_q ? count_q[last_dim_q] : LANE_BITS'(1);
				beat_q.last       <= !found;
				beat_q.status     <= STAT_OK;
				if (found) begin
					offset_q <= offset_q + inc_q[sel];
				end
			end
			OP_ERROR: begin
				beat_q <= '{index: '0, offset: '0, run_length: '0, last: 1'b0,
					status: chk_err};
			end
			OP_FINISHED: begin
				beat_q <= '{index: '0, offset: '0, run_length: '0, last: 1'b0,
					status: STAT_FINISHED};
			end
			default: ;
		endcase
	end

	assign stat.chk_err   = chk_err;
	assign stat.walk_done = walk_done_q;
	assign stat.dim_zero  = (dim_q == '0);
	assign beat           = beat_q;

endmodule

/* rtl/core/shaw_ctrl.sv */
// Controller of the address walker: handshakes, restart sequencing, beat valid.
// Depends on shaw_pkg; drives the shaw_dp command.
module shaw_ctrl import shaw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_restart,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t stat,
	output dp_op_t     op
);

	ctrl_state_t state_q, state_d;
	logic        out_valid_q;
	logic        slot_free;
	logic        emit;

	assign slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CS_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		op       = OP_NONE;
		in_ready = 1'b0;
		unique case (state_q)
			CS_IDLE: begin
				in_ready = slot_free;
				if (in_valid && slot_free) begin
					if (in_restart) begin
						op      = OP_LATCH;
						state_d = CS_CHECK;
					end else if (stat.walk_done) begin
						op = OP_FINISHED;
					end else begin
						op = OP_STEP;
					end
				end
			end
			CS_CHECK: begin
				if (stat.chk_err != STAT_OK) begin
					op      = OP_ERROR;
					state_d = CS_IDLE;
				end else begin
					state_d = CS_MUL;
				end
			end
			CS_MUL: begin
				op      = OP_MUL;
				state_d = CS_ACC;
			end
			CS_ACC: begin
				op      = OP_ACC;
				state_d = stat.dim_zero ? CS_FIRST : CS_MUL;
			end
			CS_FIRST: begin
				op      = OP_STEP;
				state_d = CS_IDLE;
			end
			default: begin
				state_d = CS_IDLE;
			end
		endcase
	end

	assign emit      = (op == OP_STEP) || (op == OP_ERROR) || (op == OP_FINISHED);
	assign out_valid = out_valid_q;

endmodule

/* rtl/core/strided_hyperslab_address_walker.sv */
// Strided hyperslab address walker, top level: controller plus datapath.
// Depends on shaw_pkg, shaw_if, shaw_ctrl, shaw_dp and assert_macros.svh.
//
// A request beat with restart low returns the next transfer descriptor (start
// index per dimension, byte offset, run length, last mark), or a finished
// status beat once the walk is done, and is taken every cycle while the result
// side keeps up and no restart is in progress; the odometer step is one add per
// beat. A restart beat latches the registers and checks them (a register error
// sends an error beat instead), then builds the per-dimension maps and offset
// increments on one shared count-by-map multiplier, a multiply and an accumulate
// step per dimension. Register writes take effect at the next restart.
`include "assert_macros.svh"

module strided_hyperslab_address_walker import shaw_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	shaw_req_if.sink                req,
	shaw_rsp_if.source              rsp,
	input  logic                    wr_en,
	input  logic [CFG_IDX_BITS-1:0] wr_index,
	input  logic [CFG_BITS-1:0]     wr_data
);

	cfg_wr_t    cfg_wr;
	dp_op_t     op;
	dp_status_t stat;
	out_beat_t  beat;

	assign cfg_wr.we    = wr_en;
	assign cfg_wr.index = wr_index;
	assign cfg_wr.data  = wr_data;

	shaw_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (req.valid),
		.in_restart (req.restart),
		.in_ready   (req.ready),
		.out_valid  (rsp.valid),
		.out_ready  (rsp.ready),
		.stat       (stat),
		.op         (op)
	);

	shaw_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_wr (cfg_wr),
		.op     (op),
		.stat   (stat),
		.beat   (beat)
	);

	assign rsp.index_0    = beat.index[0];
	assign rsp.index_1    = beat.index[1];
	assign rsp.index_2    = beat.index[2];
	assign rsp.index_3    = beat.index[3];
	assign rsp.offset     = beat.offset;
	assign rsp.run_length = beat.run_length;
	assign rsp.last       = beat.last;
	assign rsp.status     = beat.status;

	`ASSERT_NEXT(a_restart_no_beat, clk, arst_n, req.valid && req.ready && req.restart, !rsp.valid)
	`ASSERT_IMPL(a_last_is_ok, clk, arst_n, rsp.valid && rsp.last, rsp.status == STAT_OK)
	`ASSERT_IMPL(a_ready_slot, clk, arst_n, req.ready, !rsp.valid || rsp.ready)
	`ASSERT_IMPL(a_err_zero, clk, arst_n, rsp.valid && rsp.status != STAT_OK, rsp.offset == '0 && rsp.run_length == '0)

endmodule
